// ----- rtl/core/block_bitmap_allocator_core_macros.svh -----
// Assertion macros for the bitmap allocator checker.
// Depends on nothing; included by the checker file only.
`ifndef BLOCK_BITMAP_ALLOCATOR_CORE_MACROS_SVH
`define BLOCK_BITMAP_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define BBA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset-qualified.
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/bba_pkg.sv -----
// Package for the bitmap block allocator: field widths, codes, payload structs.
// No dependencies; used by the core and its checker.
package bba_pkg;

    localparam int BBA_NUM_WORDS = 256;
    localparam int BBA_WORD_BITS = 32;

    localparam int FUNC_W   = 2;
    localparam int IDX_W    = 14;
    localparam int RES_W    = 13;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 14;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOFREE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RSVD   = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  block_index;
    } bba_req_t;

    typedef struct packed {
        logic [RES_W-1:0]    result_index;
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    free_blocks;
    } bba_rsp_t;

endpackage

// ----- rtl/core/block_bitmap_allocator_core.sv -----
// Flow: a request goes through the decode, memory read and read-modify-write steps;
// the result is registered at the end of the last step, which waits for a free output slot.
// A new request is taken only in the idle state, after the previous write-back is done.
// Reset: asynchronous, active low. A clearing pass then zeroes every word of the
//   bitmap memory; req_ready stays low until it is done.
module block_bitmap_allocator_core
    import bba_pkg::*;
#(
    parameter int NUM_WORDS = BBA_NUM_WORDS,
    parameter int WORD_BITS = BBA_WORD_BITS
)(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  bba_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output bba_rsp_t rsp
);

    localparam int TOTAL  = NUM_WORDS * WORD_BITS;
    localparam int WAW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int OFW    = $clog2(WORD_BITS);
    localparam int CNTW   = $clog2(TOTAL + 1);
    localparam int BASEW  = $clog2(TOTAL);
    // Exact floor(idx / WORD_BITS) for any 14-bit idx: multiply by a
    // rounded-up reciprocal and shift.
    localparam int DIV_SH = IDX_W + OFW;
    localparam int DIV_M  = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int DIV_MW = $clog2(DIV_M + 1);
    localparam int PRODW  = IDX_W + DIV_MW;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_READ,
        S_MODIFY
    } state_t;

    // Bitmap store: one word per entry, set bit = used, MSB = lowest block.
    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [WORD_BITS-1:0] rdata_reg;

    logic                 mem_we;
    logic [WAW-1:0]       mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    state_t               state_reg,  state_next;
    logic [WAW-1:0]       clr_reg,    clr_next;
    logic [FUNC_W-1:0]    func_reg,   func_next;
    logic [IDX_W-1:0]     idx_reg,    idx_next;
    logic [WAW-1:0]       word_reg,   word_next;
    logic [BASEW-1:0]     base_reg,   base_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 act_reg,    act_next;
    logic [NUM_WORDS-1:0] full_reg,   full_next;
    logic [CNTW-1:0]      count_reg,  count_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    bba_rsp_t             rsp_reg,    rsp_next;

    // Summary search: lowest word that still has a free block.
    logic [NUM_WORDS-1:0] nf_vec;
    logic [NUM_WORDS-1:0] nf_oh;
    logic [WAW-1:0]       word_enc;
    logic                 any_nf;

    // Index split for free / mark.
    logic [PRODW-1:0]     div_prod;
    logic [IDX_W-1:0]     div_q;
    logic                 idx_range;

    // Word modify.
    logic [WORD_BITS-1:0] free_rev;
    logic [WORD_BITS-1:0] fz_oh;
    logic [OFW-1:0]       off_alloc;
    logic [OFW-1:0]       off_idx;
    logic [OFW-1:0]       off_sel;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] new_word;
    logic [31:0]          idx_diff;
    logic [31:0]          alloc_idx;
    logic                 rsp_slot;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // First-fit over the word summary: isolate lowest set bit, then encode.
    always_comb
    begin
        nf_vec   = ~full_reg;
        nf_oh    = nf_vec & (~nf_vec + 1'b1);
        any_nf   = |nf_vec;
        word_enc = '0;
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            if (nf_oh[i])
            begin
                word_enc = word_enc | WAW'(i);
            end
        end
    end

    assign div_prod  = PRODW'(idx_reg) * PRODW'(DIV_M);
    assign div_q     = IDX_W'(div_prod >> DIV_SH);
    assign idx_range = (32'(idx_reg) >= 32'(TOTAL));

    // First free block in the word: reverse so block offset 0 is bit 0.
    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            free_rev[j] = ~rdata_reg[WORD_BITS-1-j];
        end
        fz_oh     = free_rev & (~free_rev + 1'b1);
        off_alloc = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (fz_oh[j])
            begin
                off_alloc = off_alloc | OFW'(j);
            end
        end
    end

    assign idx_diff  = 32'(idx_reg) - 32'(base_reg);
    assign off_idx   = idx_diff[OFW-1:0];
    assign off_sel   = (func_reg == FUNC_ALLOC) ? off_alloc : off_idx;
    assign bit_mask  = WORD_BITS'(1) << (OFW'(WORD_BITS - 1) - off_sel);
    assign new_word  = (func_reg == FUNC_FREE) ? (rdata_reg & ~bit_mask)
                                               : (rdata_reg | bit_mask);
    assign alloc_idx = 32'(base_reg) + 32'(off_alloc);
    assign rsp_slot  = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        func_next      = func_reg;
        idx_next       = idx_reg;
        word_next      = word_reg;
        base_next      = base_reg;
        status_next    = status_reg;
        act_next       = act_reg;
        full_next      = full_reg;
        count_next     = count_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        mem_we         = 1'b0;
        mem_waddr      = word_reg;
        mem_wdata      = new_word;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == WAW'(NUM_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    func_next  = req.func;
                    idx_next   = req.block_index;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (func_reg)
                    FUNC_ALLOC:
                    begin
                        word_next   = word_enc;
                        act_next    = any_nf;
                        status_next = any_nf ? STATUS_OK : STATUS_NOFREE;
                    end
                    FUNC_FREE, FUNC_MARK:
                    begin
                        word_next   = div_q[WAW-1:0];
                        act_next    = !idx_range;
                        status_next = idx_range ? STATUS_RANGE : STATUS_OK;
                    end
                    default:
                    begin
                        act_next    = 1'b0;
                        status_next = STATUS_OK;
                    end
                endcase
                state_next = S_READ;
            end
            S_READ:
            begin
                base_next  = BASEW'(int'(word_reg) * WORD_BITS);
                state_next = S_MODIFY;
            end
            S_MODIFY:
            begin
                if (rsp_slot)
                begin
                    rsp_next.result_index = '0;
                    if (act_reg)
                    begin
                        mem_we              = 1'b1;
                        full_next[word_reg] = &new_word;
                        case (func_reg)
                            FUNC_ALLOC:
                            begin
                                rsp_next.result_index = RES_W'(alloc_idx);
                                if (count_reg != '0)
                                begin
                                    count_next = count_reg - 1'b1;
                                end
                            end
                            FUNC_FREE:
                            begin
                                rsp_next.result_index = RES_W'(idx_reg);
                                if (32'(count_reg) < 32'(TOTAL))
                                begin
                                    count_next = count_reg + 1'b1;
                                end
                            end
                            default:
                            begin
                                rsp_next.result_index = RES_W'(idx_reg);
                            end
                        endcase
                    end
                    rsp_next.status      = status_reg;
                    rsp_next.free_blocks = CNT_W'(count_next);
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            func_reg      <= '0;
            idx_reg       <= '0;
            word_reg      <= '0;
            base_reg      <= '0;
            status_reg    <= STATUS_OK;
            act_reg       <= 1'b0;
            full_reg      <= '0;
            count_reg     <= CNTW'(TOTAL);
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            func_reg      <= func_next;
            idx_reg       <= idx_next;
            word_reg      <= word_next;
            base_reg      <= base_next;
            status_reg    <= status_next;
            act_reg       <= act_next;
            full_reg      <= full_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    // Synchronous bitmap memory, registered read at the current word.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[word_reg];
    end

endmodule

// ----- rtl/core/bba_checker.sv -----
// Port-level checker for block_bitmap_allocator_core, bound into every instance of the core.
// Depends on bba_pkg and block_bitmap_allocator_core_macros.svh.
`include "block_bitmap_allocator_core_macros.svh"

module bba_checker
    import bba_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input bba_req_t req,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input bba_rsp_t rsp
);

    `BBA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response dropped or changed while stalled")

    `BBA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready, "second request taken while one is in flight")

    `BBA_ASSERT_SAME(a_status_code, clk, rst_n, rsp_valid, rsp.status != STATUS_RSVD, "reserved status code")

    `BBA_ASSERT_SAME(a_err_index, clk, rst_n, rsp_valid && (rsp.status == STATUS_RANGE || rsp.status == STATUS_NOFREE), rsp.result_index == '0, "error response with nonzero index")

endmodule

bind block_bitmap_allocator_core bba_checker u_bba_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ----- verif/tb_top.sv -----
// Self-checking testbench for block_bitmap_allocator_core: allocate, free, mark-used
// and no-op transfers are checked field by field against a first-fit model or a pinned response.
// Depends on bba_pkg and the core RTL only.
module tb_top;
    import bba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Selector value 3 has no package name: the core treats it as a no-op
    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

    localparam int TOTAL_BLOCKS = BBA_NUM_WORDS * BBA_WORD_BITS;
    localparam int QUIET_LIMIT  = 2000;   // covers the bitmap clearing pass after reset
    localparam int SEGMENTS     = 14;
    localparam int SEG_ITEMS    = 90;
    localparam int ALLOC_RUN    = 48;
    localparam int MAX_REPORTS  = 60;

    // Directed row: request plus, where pinned, a hand-derived response
    typedef struct packed {
        bba_req_t op;
        logic     pinned;
        bba_rsp_t rsp;
    } dir_row_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    bba_req_t req;
    logic     rsp_valid;
    logic     rsp_ready;
    bba_rsp_t rsp;

    // Predictor state
    logic [BBA_WORD_BITS-1:0] bitmap_model [BBA_NUM_WORDS];
    logic [CNT_W-1:0]         free_model;
    int                       blocks_used;

    bba_rsp_t due_rsp_q [$];
    bba_rsp_t pinned_rsp;
    logic     pinned_use;

    logic idling;
    int   mismatches;
    int   quiet_cycles;
    int   func_seen [4];
    int   status_seen [4];

    dir_row_t dir_rows [22] = '{
        '{'{FUNC_ALLOC, 14'd0},     1'b1, '{13'd0,    STATUS_OK,    14'd8191}},
        '{'{FUNC_ALLOC, 14'd16383}, 1'b1, '{13'd1,    STATUS_OK,    14'd8190}},
        '{'{FUNC_MARK,  14'd8191},  1'b1, '{13'd8191, STATUS_OK,    14'd8190}},
        '{'{FUNC_FREE,  14'd8191},  1'b1, '{13'd8191, STATUS_OK,    14'd8191}},
        '{'{FUNC_FREE,  14'd0},     1'b1, '{13'd0,    STATUS_OK,    14'd8192}},
        // freeing a free block at the full count: saturates
        '{'{FUNC_FREE,  14'd0},     1'b1, '{13'd0,    STATUS_OK,    14'd8192}},
        '{'{FUNC_FREE,  14'd8192},  1'b1, '{13'd0,    STATUS_RANGE, 14'd8192}},
        '{'{FUNC_MARK,  14'd16383}, 1'b1, '{13'd0,    STATUS_RANGE, 14'd8192}},
        '{'{FUNC_NOP,   14'd16383}, 1'b1, '{13'd0,    STATUS_OK,    14'd8192}},
        '{'{FUNC_ALLOC, 14'd0},     1'b1, '{13'd0,    STATUS_OK,    14'd8191}},
        // marking a free block leaves the count alone
        '{'{FUNC_MARK,  14'd2},     1'b1, '{13'd2,    STATUS_OK,    14'd8191}},
        '{'{FUNC_ALLOC, 14'd0},     1'b1, '{13'd3,    STATUS_OK,    14'd8190}},
        // freeing a block that is already free still bumps the count
        '{'{FUNC_FREE,  14'd100},   1'b1, '{13'd100,  STATUS_OK,    14'd8191}},
        '{'{FUNC_MARK,  14'd31},    1'b0, '0},
        '{'{FUNC_MARK,  14'd32},    1'b0, '0},
        '{'{FUNC_FREE,  14'd1},     1'b0, '0},
        '{'{FUNC_ALLOC, 14'd5461},  1'b0, '0},
        '{'{FUNC_MARK,  14'd12345}, 1'b0, '0},
        '{'{FUNC_NOP,   14'd0},     1'b0, '0},
        '{'{FUNC_FREE,  14'd10922}, 1'b0, '0},
        '{'{FUNC_MARK,  14'd5461},  1'b0, '0},
        '{'{FUNC_ALLOC, 14'd10922}, 1'b0, '0}
    };

    block_bitmap_allocator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // First-fit allocate, free and mark predictor: bit WORD_BITS-1 of a word is its lowest block.
    function automatic bba_rsp_t predict_alloc_op(input bba_req_t op);
        bba_rsp_t r;
        int       w;
        int       k;
        int       bitpos;
        logic     found;
        r = '0;
        r.status = STATUS_OK;
        found = 1'b0;
        case (op.func)
            FUNC_ALLOC:
            begin
                r.status = STATUS_NOFREE;
                for (w = 0; w < BBA_NUM_WORDS && !found; w++)
                begin
                    if (!(&bitmap_model[w]))
                    begin
                        for (k = 0; k < BBA_WORD_BITS && !found; k++)
                        begin
                            if (!bitmap_model[w][BBA_WORD_BITS-1-k])
                            begin
                                bitmap_model[w][BBA_WORD_BITS-1-k] = 1'b1;
                                blocks_used++;
                                if (free_model != '0)
                                    free_model--;
                                r.result_index = RES_W'(w * BBA_WORD_BITS + k);
                                r.status = STATUS_OK;
                                found = 1'b1;
                            end
                        end
                    end
                end
            end
            FUNC_FREE, FUNC_MARK:
            begin
                if (int'(op.block_index) >= TOTAL_BLOCKS)
                    r.status = STATUS_RANGE;
                else
                begin
                    w = int'(op.block_index) / BBA_WORD_BITS;
                    bitpos = BBA_WORD_BITS - 1 - int'(op.block_index) % BBA_WORD_BITS;
                    if (op.func == FUNC_FREE)
                    begin
                        if (bitmap_model[w][bitpos])
                            blocks_used--;
                        bitmap_model[w][bitpos] = 1'b0;
                        if (int'(free_model) < TOTAL_BLOCKS)
                            free_model++;
                    end
                    else
                    begin
                        if (!bitmap_model[w][bitpos])
                            blocks_used++;
                        bitmap_model[w][bitpos] = 1'b1;
                    end
                    r.result_index = op.block_index[RES_W-1:0];
                end
            end
            default: ;
        endcase
        r.free_blocks = free_model;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ERROR %s", $time, msg);
    endtask

    // Response check first, then the prediction for a request transfer on the same edge,
    // so a result can never be matched against its own request.
    always @(posedge clk)
    begin : rsp_check
        bba_rsp_t want;
        bba_rsp_t model_rsp;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            status_seen[rsp.status]++;
            if (due_rsp_q.size() == 0)
                report_mismatch($sformatf("result with nothing outstanding: idx %0d st %0d",
                                          rsp.result_index, rsp.status));
            else
            begin
                want = due_rsp_q.pop_front();
                if (rsp.result_index !== want.result_index)
                    report_mismatch($sformatf("result_index got %0d want %0d",
                                              rsp.result_index, want.result_index));
                if (rsp.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              rsp.status, want.status));
                if (rsp.free_blocks !== want.free_blocks)
                    report_mismatch($sformatf("free_blocks got %0d want %0d",
                                              rsp.free_blocks, want.free_blocks));
            end
        end
        if (rst_n && req_valid && req_ready)
        begin
            func_seen[req.func]++;
            model_rsp = predict_alloc_op(req);
            due_rsp_q.push_back(pinned_use ? pinned_rsp : model_rsp);
        end
    end

    // Cycles without any transfer; the clearing pass after reset fits well inside the limit
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t ERROR watchdog: no transfer for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, due_rsp_q.size());
        $display("tb_top: FAIL");
        $finish;
    end

    // Receiver: stalls in random bursts while idling is on
    initial
    begin : rsp_sink
        int stall_left;
        stall_left = 0;
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_ready = 1'b0;
                stall_left--;
            end
            else if (idling && $urandom_range(0, 5) == 0)
            begin
                rsp_ready = 1'b0;
                stall_left = $urandom_range(1, 17) - 1;
            end
            else
                rsp_ready = 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer with valid
    // still high, so the caller either sends again at once or lowers it.
    task automatic send_op(input bba_req_t op, input logic pin, input bba_rsp_t pin_rsp);
        int gap;
        if (idling && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 17);
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req        = op;
        pinned_use = pin;
        pinned_rsp = pin_rsp;
        req_valid  = 1'b1;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        @(negedge clk);
    endtask

    task automatic drain_results();
        req_valid = 1'b0;
        while (due_rsp_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Mostly allocations and frees around a hot region, so the scan meets holes
    function automatic bba_req_t random_op();
        bba_req_t op;
        int       pick;
        pick = $urandom_range(0, 99);
        op.block_index = IDX_W'($urandom_range(0, 16383));
        if (pick < 40)
            op.func = FUNC_ALLOC;
        else if (pick < 90)
        begin
            op.func = (pick < 70) ? FUNC_FREE : FUNC_MARK;
            if ($urandom_range(0, 3) != 0)
                op.block_index = IDX_W'($urandom_range(0, 1023));
            else
                op.block_index = IDX_W'($urandom_range(0, TOTAL_BLOCKS - 1));
        end
        else if (pick < 94)
            op.func = FUNC_NOP;
        else
        begin
            op.func = $urandom_range(0, 1) ? FUNC_FREE : FUNC_MARK;
            op.block_index = IDX_W'($urandom_range(TOTAL_BLOCKS, 16383));
        end
        return op;
    endfunction

    initial
    begin : stimulus
        bba_req_t op;
        int       i;
        int       seg;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        pinned_use  = 1'b0;
        pinned_rsp  = '0;
        idling      = 1'b0;
        mismatches  = 0;
        blocks_used = 0;
        free_model  = CNT_W'(TOTAL_BLOCKS);
        for (i = 0; i < BBA_NUM_WORDS; i++)
            bitmap_model[i] = '0;
        for (i = 0; i < 4; i++)
        begin
            func_seen[i] = 0;
            status_seen[i] = 0;
        end
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, range errors, no-op, reuse of freed blocks
        idling = 1'b1;
        foreach (dir_rows[i])
            send_op(dir_rows[i].op, dir_rows[i].pinned, dir_rows[i].rsp);
        drain_results();

        // Random segments; some with idling off, some opened by a full drain
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            idling = (seg % 4 != 3) && (seg != SEGMENTS - 1);
            if (seg % 5 == 0)
                drain_results();
            for (i = 0; i < SEG_ITEMS; i++)
                send_op(random_op(), 1'b0, '0);
        end

        // Back-to-back allocation run with a few marks, then reuse of freed blocks
        idling = 1'b0;
        for (i = 0; i < ALLOC_RUN; i++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                op.func = FUNC_MARK;
                op.block_index = IDX_W'($urandom_range(0, TOTAL_BLOCKS - 1));
            end
            else
            begin
                op.func = FUNC_ALLOC;
                op.block_index = IDX_W'($urandom_range(0, 16383));
            end
            send_op(op, 1'b0, '0);
        end
        send_op('{FUNC_ALLOC, 14'd0},    1'b0, '0);
        send_op('{FUNC_FREE,  14'd4000}, 1'b0, '0);
        send_op('{FUNC_ALLOC, 14'd0},    1'b0, '0);
        send_op('{FUNC_ALLOC, 14'd0},    1'b0, '0);
        send_op('{FUNC_MARK,  14'd8191}, 1'b0, '0);
        send_op('{FUNC_FREE,  14'd8191}, 1'b0, '0);
        send_op('{FUNC_FREE,  14'd8191}, 1'b0, '0);
        send_op('{FUNC_ALLOC, 14'd0},    1'b0, '0);
        send_op('{FUNC_ALLOC, 14'd0},    1'b0, '0);
        req_valid = 1'b0;

        while (due_rsp_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Requests: %0d allocate, %0d free, %0d mark, %0d no-op; %0d blocks in use",
                 func_seen[FUNC_ALLOC], func_seen[FUNC_FREE], func_seen[FUNC_MARK],
                 func_seen[FUNC_NOP], blocks_used);
        $display("Results: %0d ok, %0d out of range, %0d no free block; %0d mismatches",
                 status_seen[STATUS_OK], status_seen[STATUS_RANGE],
                 status_seen[STATUS_NOFREE], mismatches);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/bba_pkg.sv
rtl/core/block_bitmap_allocator_core.sv
rtl/core/bba_checker.sv
verif/tb_top.sv
